// ===== rtl/transport_header_field_parser_core_defines.svh =====
// Assertion macros for the transport header field parser core.
`ifndef TRANSPORT_HEADER_FIELD_PARSER_CORE_DEFINES_SVH
`define TRANSPORT_HEADER_FIELD_PARSER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, quiet while reset is asserted.
`define THFP_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, also watched during reset.
`define THFP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define THFP_ASSERT(name, clk, rstn, prop, msg)
`define THFP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== rtl/thfp_pkg.sv =====
// Shared constants, keyword tables and helpers for the transport header parser.
`timescale 1ns / 1ps
`default_nettype none
package thfp_pkg;

    localparam int TAG_BUFFER_LEN = 64;
    localparam int KW_COUNT       = 7;
    localparam int KW_MAX_LEN     = 11;

    localparam logic [6:0] TAG_MAX   = 7'd127;
    localparam logic [6:0] TAG_LIMIT = 7'(TAG_BUFFER_LEN - 1);
    localparam logic [6:0] KW_ALL    = 7'h7F;
    localparam logic [15:0] NUM_MAX  = 16'hFFFF;
    localparam logic [8:0] OCT_OVER  = 9'd257;

    localparam logic [2:0] MODE_TAG  = 3'd0;
    localparam logic [2:0] MODE_SRV  = 3'd1;
    localparam logic [2:0] MODE_CLI  = 3'd2;
    localparam logic [2:0] MODE_TTL  = 3'd3;
    localparam logic [2:0] MODE_DEST = 3'd4;
    localparam logic [2:0] MODE_SRC  = 3'd5;
    localparam logic [2:0] MODE_SSRC = 3'd6;

    // keyword text, left aligned and space padded, first char in the top byte
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        "port       ", {"client", "_port"}, {"server", "_port"}, "ttl        ",
        "destination", "source     ", "ssrc       "
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd11, 4'd11, 4'd3, 4'd11, 4'd6, 4'd4
    };
    localparam logic [2:0] KW_MODE [KW_COUNT] = '{
        MODE_SRV, MODE_CLI, MODE_SRV, MODE_TTL, MODE_DEST, MODE_SRC, MODE_SSRC
    };

    typedef struct packed {
        logic [6:0] hits;
        logic [2:0] end_mode;
    } tag_match_t;

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        logic [3:0] slot;
        slot = 4'(KW_MAX_LEN - 1) - pos;
        return KW_TEXT[k][8*slot +: 8];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/transport_header_field_parser_core.sv =====
// Top level: RTSP transport header field parser, one header byte per beat.
// Datapath: an accepted byte is held in the input register and processed from
// there; a zero byte loads the result register that drives m_axis.
// Throughput: one byte per cycle, except that a zero byte waits in the input
// register while an earlier result beat is still stalled on m_axis.
// Reset (aresetn low, synchronous): parse restarts, held values clear to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "transport_header_field_parser_core_defines.svh"
module transport_header_field_parser_core
    import thfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // server port, client port, ttl_value, dest_address
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [71:0] out_data_reg;

    logic [2:0]  mode_reg, mode_next;
    logic [6:0]  tag_len_reg, tag_len_next;
    logic [6:0]  hits_reg, hits_next;
    logic [15:0] num_reg, num_next;
    logic [8:0]  oct_reg, oct_next;
    logic [1:0]  oct_cnt_reg, oct_cnt_next;
    logic        bad_reg, bad_next;
    logic [23:0] build_reg, build_next;
    logic [15:0] srv_reg, srv_next;
    logic [15:0] cli_reg, cli_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [31:0] addr_reg, addr_next;

    logic        adv;
    logic        zero_byte;
    logic        is_digit;
    logic [3:0]  digit;
    logic [19:0] num_prod;
    logic [11:0] oct_prod;
    logic [7:0]  oct_val;
    logic        oct_ok;
    tag_match_t  tm;

    thfp_tag_match u_tag_match (
        .tag_len (tag_len_reg),
        .hits    (hits_reg),
        .ch      (in_byte_reg),
        .result  (tm)
    );

    assign zero_byte     = (in_byte_reg == 8'd0);
    assign adv           = in_valid_reg && (!zero_byte || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign is_digit = (in_byte_reg >= "0") && (in_byte_reg <= "9");
    assign digit    = 4'(in_byte_reg - 8'h30);
    assign num_prod = {4'd0, num_reg} * 20'd10 + {16'd0, digit};
    assign oct_val  = 8'(oct_reg - 9'd1);
    assign oct_prod = {4'd0, oct_val} * 12'd10 + {8'd0, digit};
    assign oct_ok   = (oct_reg != 9'd0) && (oct_reg < OCT_OVER);

    always_comb begin
        mode_next    = mode_reg;
        tag_len_next = tag_len_reg;
        hits_next    = hits_reg;
        num_next     = num_reg;
        oct_next     = oct_reg;
        oct_cnt_next = oct_cnt_reg;
        bad_next     = bad_reg;
        build_next   = build_reg;
        srv_next     = srv_reg;
        cli_next     = cli_reg;
        ttl_next     = ttl_reg;
        addr_next    = addr_reg;

        case (mode_reg)
            MODE_TAG: begin
                if (in_byte_reg inside {";", ",", "=", 8'h0A}) begin
                    tag_len_next = '0;
                    hits_next    = KW_ALL;
                    num_next     = '0;
                    oct_next     = '0;
                    oct_cnt_next = '0;
                    bad_next     = 1'b0;
                    build_next   = '0;
                    mode_next    = tm.end_mode;
                end else if (!zero_byte) begin
                    hits_next = tm.hits;
                    if (tag_len_reg < TAG_MAX) begin
                        tag_len_next = tag_len_reg + 7'd1;
                    end
                end
            end
            MODE_SRV, MODE_CLI, MODE_TTL: begin
                if (is_digit) begin
                    num_next = (num_prod > {4'd0, NUM_MAX}) ? NUM_MAX : num_prod[15:0];
                end else begin
                    if (mode_reg == MODE_SRV) begin
                        srv_next = num_reg;
                    end else if (mode_reg == MODE_CLI) begin
                        cli_next = num_reg;
                    end else begin
                        ttl_next = (num_reg > 16'd255) ? 8'd255 : num_reg[7:0];
                    end
                    num_next  = '0;
                    mode_next = MODE_TAG;
                end
            end
            MODE_DEST, MODE_SRC: begin
                if (is_digit) begin
                    if (oct_reg == 9'd0) begin
                        oct_next = {5'd0, digit} + 9'd1;
                    end else if (oct_reg < OCT_OVER) begin
                        oct_next = (oct_prod > 12'd255) ? OCT_OVER
                                                        : 9'(oct_prod + 12'd1);
                    end
                end else if (in_byte_reg == ".") begin
                    if (oct_cnt_reg == 2'd3 || !oct_ok) begin
                        bad_next = 1'b1;
                    end else begin
                        build_next   = {build_reg[15:0], oct_val};
                        oct_cnt_next = oct_cnt_reg + 2'd1;
                    end
                    oct_next = '0;
                end else begin
                    if (!bad_reg && oct_cnt_reg == 2'd3 && oct_ok) begin
                        addr_next = {build_reg, oct_val};
                    end
                    oct_next     = '0;
                    oct_cnt_next = '0;
                    bad_next     = 1'b0;
                    build_next   = '0;
                    num_next     = '0;
                    mode_next    = (mode_reg == MODE_DEST && in_byte_reg == ":")
                                   ? MODE_CLI : MODE_TAG;
                end
            end
            default: begin
            end
        endcase

        // end of string: restart the parse, held values stay
        if (zero_byte) begin
            mode_next    = MODE_TAG;
            tag_len_next = '0;
            hits_next    = KW_ALL;
            num_next     = '0;
            oct_next     = '0;
            oct_cnt_next = '0;
            bad_next     = 1'b0;
            build_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_TAG;
            tag_len_reg   <= '0;
            hits_reg      <= KW_ALL;
            num_reg       <= '0;
            oct_reg       <= '0;
            oct_cnt_reg   <= '0;
            bad_reg       <= 1'b0;
            build_reg     <= '0;
            srv_reg       <= '0;
            cli_reg       <= '0;
            ttl_reg       <= '0;
            addr_reg      <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv) begin
                mode_reg    <= mode_next;
                tag_len_reg <= tag_len_next;
                hits_reg    <= hits_next;
                num_reg     <= num_next;
                oct_reg     <= oct_next;
                oct_cnt_reg <= oct_cnt_next;
                bad_reg     <= bad_next;
                build_reg   <= build_next;
                srv_reg     <= srv_next;
                cli_reg     <= cli_next;
                ttl_reg     <= ttl_next;
                addr_reg    <= addr_next;
            end
            if (adv && zero_byte) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
        if (adv && zero_byte) begin
            out_data_reg <= {addr_next, ttl_next, cli_next, srv_next};
        end
    end

    `THFP_ASSERT(a_no_result_overrun, aclk, aresetn, !(adv && zero_byte && out_valid_reg && !m_axis_tready), "result beat overwritten while stalled")
    `THFP_ASSERT(a_zero_gives_result, aclk, aresetn, (adv && zero_byte) |=> out_valid_reg, "zero byte produced no result beat")
    `THFP_ASSERT(a_tag_len_in_tag, aclk, aresetn, (tag_len_reg != 7'd0) |-> (mode_reg == MODE_TAG), "tag length held outside tag text")
    `THFP_ASSERT(a_octets_in_addr, aclk, aresetn, (oct_cnt_reg != 2'd0) |-> (mode_reg == MODE_DEST || mode_reg == MODE_SRC), "octet count held outside address")

endmodule
`default_nettype wire

// ===== rtl/thfp_tag_match.sv =====
// Per-byte keyword matcher and end-of-tag keyword select.
`timescale 1ns / 1ps
`default_nettype none
module thfp_tag_match
    import thfp_pkg::*;
(
    input  wire logic [6:0] tag_len,
    input  wire logic [6:0] hits,
    input  wire logic [7:0] ch,
    output tag_match_t      result
);

    logic [7:0] lc;

    always_comb begin
        lc = to_lower(ch);
        result.hits = hits;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (tag_len >= {3'd0, KW_LEN[k]}) begin
                result.hits[k] = 1'b0;
            end else if (kw_char(k, tag_len[3:0]) != lc) begin
                result.hits[k] = 1'b0;
            end
        end

        // first keyword in list order wins
        result.end_mode = MODE_TAG;
        if (tag_len <= TAG_LIMIT) begin
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
                if (hits[k] && {3'd0, KW_LEN[k]} == tag_len) begin
                    result.end_mode = KW_MODE[k];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== bench/tb_transport_header_field_parser_core.sv =====
// Self-checking testbench for the RTSP transport header field parser core.
`timescale 1ns / 1ps
module tb_transport_header_field_parser_core;
    import thfp_pkg::*;

    typedef struct packed {
        logic [31:0] dest_address;
        logic [7:0]  ttl_value;
        logic [15:0] cli_port;
        logic [15:0] srv_port;
    } transport_fields_t;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int MAX_REPORTS    = 10;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // char_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;            // server port, client port, ttl_value, dest_address

    transport_header_field_parser_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    string       kw_names [KW_COUNT] = '{"port", {string'("client"), "_port"},
                                          {string'("server"), "_port"}, "ttl",
                                          "destination", "source", "ssrc"};
    logic [2:0]  parse_mode    = MODE_TAG;
    logic [6:0]  tag_len       = '0;
    logic [6:0]  keyword_hits  = KW_ALL;
    int unsigned num_accum     = 0;
    int unsigned oct_accum     = 0;
    int unsigned oct_count     = 0;
    bit          addr_bad      = 1'b0;
    logic [31:0] addr_build    = '0;
    logic [15:0] held_srv_port = '0;
    logic [15:0] held_cli_port = '0;
    logic [7:0]  held_ttl      = '0;
    logic [31:0] held_addr     = '0;

    transport_fields_t expected_fields [$];
    logic [7:0]        frame_bytes [$];

    int   send_idle_pct  = 0;
    int   stall_pct      = 0;
    bit   holding        = 1'b0;
    int   failures       = 0;
    int   bytes_accepted = 0;
    int   results_seen   = 0;
    int   headers_sent   = 0;
    int   idle_cycles    = 0;
    event hold_kick;

    function void restart_header();
        tag_len      = '0;
        keyword_hits = KW_ALL;
        num_accum    = 0;
        oct_accum    = 0;
        oct_count    = 0;
        addr_bad     = 1'b0;
        addr_build   = '0;
    endfunction

    function void parse_header_byte(input logic [7:0] raw);
        logic [7:0]        c;
        logic [2:0]        next_mode;
        int unsigned       v;
        bit                to_port;
        transport_fields_t fields;
        c = raw;
        case (parse_mode)
            MODE_TAG: begin
                if (c == ";" || c == "," || c == "=" || c == "\n") begin
                    next_mode = MODE_TAG;
                    if (tag_len <= TAG_LIMIT) begin
                        for (int k = KW_COUNT - 1; k >= 0; k--)
                            if (keyword_hits[k] && kw_names[k].len() == tag_len)
                                next_mode = KW_MODE[k];
                    end
                    restart_header();
                    parse_mode = next_mode;
                end else if (c != 8'h00) begin
                    if (c >= "A" && c <= "Z")
                        c = c + 8'd32;
                    for (int k = 0; k < KW_COUNT; k++)
                        if (tag_len >= kw_names[k].len() || 8'(kw_names[k][tag_len]) != c)
                            keyword_hits[k] = 1'b0;
                    if (tag_len != TAG_MAX)
                        tag_len = tag_len + 7'd1;
                end
            end
            MODE_SRV, MODE_CLI, MODE_TTL: begin
                if (c >= "0" && c <= "9") begin
                    v = num_accum * 10 + int'(c) - 48;
                    num_accum = (v > NUM_MAX) ? NUM_MAX : v;
                end else begin
                    if (parse_mode == MODE_SRV)
                        held_srv_port = 16'(num_accum);
                    else if (parse_mode == MODE_CLI)
                        held_cli_port = 16'(num_accum);
                    else
                        held_ttl = (num_accum > 255) ? 8'd255 : 8'(num_accum);
                    num_accum  = 0;
                    parse_mode = MODE_TAG;
                end
            end
            MODE_DEST, MODE_SRC: begin
                if (c >= "0" && c <= "9") begin
                    if (oct_accum == 0) begin
                        oct_accum = int'(c) - 48 + 1;
                    end else if (oct_accum < OCT_OVER) begin
                        v = (oct_accum - 1) * 10 + int'(c) - 48;
                        oct_accum = (v > 255) ? OCT_OVER : v + 1;
                    end
                end else if (c == ".") begin
                    if (oct_count >= 3 || oct_accum == 0 || oct_accum >= OCT_OVER) begin
                        addr_bad = 1'b1;
                    end else begin
                        addr_build = {addr_build[23:0], 8'(oct_accum - 1)};
                        oct_count++;
                    end
                    oct_accum = 0;
                end else begin
                    to_port = (parse_mode == MODE_DEST && c == ":");
                    if (!addr_bad && oct_count == 3 && oct_accum != 0 && oct_accum < OCT_OVER)
                        held_addr = {addr_build[23:0], 8'(oct_accum - 1)};
                    oct_accum  = 0;
                    oct_count  = 0;
                    addr_bad   = 1'b0;
                    addr_build = '0;
                    num_accum  = 0;
                    parse_mode = to_port ? MODE_CLI : MODE_TAG;
                end
            end
            default: ;
        endcase
        if (raw == 8'h00) begin
            fields.srv_port     = held_srv_port;
            fields.cli_port     = held_cli_port;
            fields.ttl_value    = held_ttl;
            fields.dest_address = held_addr;
            expected_fields.push_back(fields);
            restart_header();
            parse_mode = MODE_TAG;
        end
    endfunction

    // result checking and input prediction, both on sampled values
    always @(posedge aclk) begin
        transport_fields_t got;
        transport_fields_t want;
        bit                bad;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                results_seen++;
                if (expected_fields.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("ERROR: unexpected result beat %h", m_axis_tdata);
                end else begin
                    want = expected_fields.pop_front();
                    bad = 1'b0;
                    if (got.srv_port !== want.srv_port)         bad = 1'b1;
                    if (got.cli_port !== want.cli_port)         bad = 1'b1;
                    if (got.ttl_value !== want.ttl_value)       bad = 1'b1;
                    if (got.dest_address !== want.dest_address) bad = 1'b1;
                    if (bad) begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display("ERROR: result %0d exp srv=%0d cli=%0d ttl=%0d addr=%h, got srv=%0d cli=%0d ttl=%0d addr=%h",
                                     results_seen, want.srv_port, want.cli_port,
                                     want.ttl_value, want.dest_address, got.srv_port,
                                     got.cli_port, got.ttl_value, got.dest_address);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_accepted++;
                parse_header_byte(s_axis_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    always @(negedge aclk)
        m_axis_tready <= !holding && ($urandom_range(99) >= stall_pct);

    always begin
        @(hold_kick);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        holding = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task send_byte(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task send_frame();
        foreach (frame_bytes[i]) begin
            send_byte(frame_bytes[i]);
            if (frame_bytes[i] == 8'h00)
                headers_sent++;
        end
        frame_bytes.delete();
    endtask

    task wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_bytes.push_back(8'(s[i]));
    endfunction

    task send_header(input string s);
        add_text(s);
        frame_bytes.push_back(8'h00);
        send_frame();
    endtask

    function void add_random_header();
        int         n_fields;
        int         kind;
        int         len;
        int         parts;
        int         r;
        logic [7:0] c;
        string      delims;
        delims = "=;,\n";
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(1, 24);
            repeat (len) frame_bytes.push_back(8'($urandom_range(1, 255)));
        end else begin
            n_fields = $urandom_range(1, 4);
            for (int f = 0; f < n_fields; f++) begin
                kind = $urandom_range(0, KW_COUNT);
                if (kind == KW_COUNT) begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(12, 130)
                                                   : $urandom_range(0, 8);
                    repeat (len) frame_bytes.push_back(8'($urandom_range(1, 255)));
                end else begin
                    for (int i = 0; i < kw_names[kind].len(); i++) begin
                        c = 8'(kw_names[kind][i]);
                        if (c >= "a" && c <= "z" && $urandom_range(1))
                            c = c - 8'd32;
                        frame_bytes.push_back(c);
                    end
                    if ($urandom_range(7) == 0)
                        frame_bytes.push_back(8'("a" + $urandom_range(25)));
                end
                frame_bytes.push_back($urandom_range(1) ? 8'("=") : 8'(delims[$urandom_range(3)]));
                if (kind == 4 || kind == 5) begin
                    parts = ($urandom_range(7) == 0) ? $urandom_range(1, 6) : 4;
                    for (int p = 0; p < parts; p++) begin
                        if (p > 0)
                            add_text(".");
                        r = $urandom_range(15);
                        if (r == 2)
                            add_text("0");
                        if (r == 1)
                            add_text($sformatf("%0d", $urandom_range(256, 999)));
                        else if (r != 0)
                            add_text($sformatf("%0d", $urandom_range(0, 255)));
                    end
                    if (kind == 4 && $urandom_range(2) == 0) begin
                        add_text(":");
                        len = $urandom_range(0, 6);
                        repeat (len) frame_bytes.push_back(8'("0" + $urandom_range(9)));
                    end
                end else if (kind == 6) begin
                    len = $urandom_range(0, 10);
                    repeat (len) frame_bytes.push_back(8'($urandom_range(1, 255)));
                end else if (kind < KW_COUNT) begin
                    len = $urandom_range(0, 6);
                    repeat (len) frame_bytes.push_back(8'("0" + $urandom_range(9)));
                end
                if (f != n_fields - 1 || $urandom_range(1))
                    frame_bytes.push_back(8'(delims[$urandom_range(1, 3)]));
            end
        end
        frame_bytes.push_back(8'h00);
    endfunction

    task test_directed_headers();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_header("");
        send_header("PORT=65535;Client_Port=0;TTL=999");
        send_header("SERVER_PORT=99999,destination=255.255.255.255:70000");
        send_header("source=0.0.0.0;ttl=0\n");
        send_header("destination=256.1.1.1;source=1.2.3;source=1.2.3.4.5,source=1..2.3;");
        send_header("destination=001.020.003.9");
        send_header("ssrc=12;port=5;ttl=9");
        send_header("ports=1;por=2;ttl\n7;port=");
        send_header("clie");
        send_header("destination=10.0.0.1:");
        send_header("source=1.2.3.4:5");
        repeat (130) frame_bytes.push_back(8'("x"));
        add_text("=5;");
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h80);
        send_header(";port=3");
        wait_drained();
    endtask

    task test_random_phase(input int idle_pct, input int hold_pct, input int byte_goal);
        int first_byte;
        int first_header;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        first_byte    = bytes_accepted;
        first_header  = headers_sent;
        while (bytes_accepted - first_byte < byte_goal || headers_sent - first_header < 1) begin
            add_random_header();
            send_frame();
        end
        wait_drained();
    endtask

    task test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        -> hold_kick;
        for (int i = 0; i < 12; i++)
            send_header($sformatf("ttl=%0d", i * 23));
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_headers();
        test_random_phase(0, 0, 40);
        test_random_phase(64, 0, 40);
        test_random_phase(0, 64, 40);
        test_random_phase(23, 23, 40);
        test_output_backpressure();
        wait_drained();
        repeat (8) @(posedge aclk);
        failures += expected_fields.size();
        $display("Checked %0d result beats from %0d header bytes in %0d headers,",
                 results_seen, bytes_accepted, headers_sent);
        $display("under free flow, sender gaps, receiver stalls and a long output hold.");
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
